>>> rtl/core/qsk_pkg.sv
// Shared types, codes and defaults for the queue-to-stack keyed removal core.
package qsk_pkg;

   // Default sizes
   localparam int DefWaitDepth = 16;
   localparam int DefParkDepth = 16;
   localparam int DefIdWidth   = 16;

   // Fixed widths of the item fields
   localparam int OpWidth     = 2;
   localparam int ItemIdWidth = 16;
   localparam int StatusWidth = 3;
   localparam int CountWidth  = 5;

   // Operation codes
   typedef enum logic [OpWidth-1:0] {
      OP_ENQUEUE = 2'd0,
      OP_PARK    = 2'd1,
      OP_REMOVE  = 2'd2
   } op_type;

   // Result status codes
   typedef enum logic [StatusWidth-1:0] {
      ST_OK       = 3'd0,
      ST_QEMPTY   = 3'd1,
      ST_PEMPTY   = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_QFULL    = 3'd4,
      ST_PFULL    = 3'd5
   } status_type;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_PARK_WR,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_REPLY
   } state_type;

   // Input item
   typedef struct packed {
      logic [OpWidth-1:0]     operation;
      logic [ItemIdWidth-1:0] item_id;
   } req_type;

   // Result item
   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic [ItemIdWidth-1:0] moved_id;
      logic [CountWidth-1:0]  waiting_count;
      logic [CountWidth-1:0]  parked_count;
   } rsp_type;

   // Waiting FIFO control from the sequencer
   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctl_type;

   // Waiting FIFO status to the sequencer
   typedef struct packed {
      logic empty;
      logic full;
   } fifo_stat_type;

endpackage

>>> rtl/core/qsk_fifo.sv
// Waiting-ID FIFO: circular buffer memory with head, tail and fill count.
module qsk_fifo #(
   parameter int WAIT_DEPTH = qsk_pkg::DefWaitDepth,
   parameter int ID_WIDTH   = qsk_pkg::DefIdWidth,
   parameter int CNT_WIDTH  = $clog2(WAIT_DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  qsk_pkg::fifo_ctl_type ctl,
   input  logic [ID_WIDTH-1:0]   wr_data,
   output logic [ID_WIDTH-1:0]   rd_data,
   output qsk_pkg::fifo_stat_type stat,
   output logic [CNT_WIDTH-1:0]  count
);
   import qsk_pkg::*;

   localparam int IdxWidth = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
   localparam logic [IdxWidth-1:0] LastIdx = IdxWidth'(WAIT_DEPTH - 1);

   logic [ID_WIDTH-1:0]  mem [WAIT_DEPTH];
   logic [ID_WIDTH-1:0]  rd_data_ff;
   logic [IdxWidth-1:0]  head_ff, head_in;
   logic [IdxWidth-1:0]  tail_ff, tail_in;
   logic [CNT_WIDTH-1:0] fill_ff, fill_in;

   // Advance pointers and occupancy
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (ctl.push) begin
         tail_in = (tail_ff == LastIdx) ? '0 : tail_ff + IdxWidth'(1);
         fill_in = fill_ff + CNT_WIDTH'(1);
      end
      if (ctl.pop) begin
         head_in = (head_ff == LastIdx) ? '0 : head_ff + IdxWidth'(1);
         fill_in = fill_ff - CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   // Write at tail, read oldest at head into the output register
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[tail_ff] <= wr_data;
      end
      if (ctl.pop) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   // Report occupancy flags
   always_comb begin
      stat.empty = (fill_ff == '0);
      stat.full  = (fill_ff == CNT_WIDTH'(WAIT_DEPTH));
   end

   assign rd_data = rd_data_ff;
   assign count   = fill_ff;

endmodule

>>> rtl/core/queue_to_stack_keyed_removal_core.sv
// Queue-to-stack keyed removal core: waiting FIFO, parked stack and removal sequencer.
//
// The core keeps a FIFO of waiting IDs and a parked list ordered like a stack.
// Operation 0 appends item_id to the FIFO, operation 1 moves the oldest waiting
// ID onto the parked list, operation 2 removes the most recently parked entry
// equal to item_id and closes the gap. One item is in work at a time and every
// item gives exactly one result. Enqueue, errors and unused codes go straight
// to the reply state, and a park passes through the parked-write state first.
// A remove reads and compares the parked entries newest first, then reads and
// writes each newer entry to shift it down over the gap. The parked memory has
// one write port and one registered read port, and one shared ID comparator
// checks the examined entries one at a time. A new item is accepted while the
// previous result still waits in the output register.
module queue_to_stack_keyed_removal_core #(
   parameter int WAIT_DEPTH = qsk_pkg::DefWaitDepth,
   parameter int PARK_DEPTH = qsk_pkg::DefParkDepth,
   parameter int ID_WIDTH   = qsk_pkg::DefIdWidth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  qsk_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output qsk_pkg::rsp_type rsp_payload
);
   import qsk_pkg::*;

   localparam int WCntWidth = $clog2(WAIT_DEPTH + 1);
   localparam int PCntWidth = $clog2(PARK_DEPTH + 1);
   localparam int PIdxWidth = (PARK_DEPTH > 1) ? $clog2(PARK_DEPTH) : 1;

   // Waiting FIFO
   fifo_ctl_type         fifo_ctl;
   fifo_stat_type        fifo_stat;
   logic [ID_WIDTH-1:0]  fifo_rd_data;
   logic [WCntWidth-1:0] wait_count;

   // Sequencer and datapath registers
   state_type            state_ff, state_in;
   logic [ID_WIDTH-1:0]  id_ff, id_in;
   logic [PIdxWidth-1:0] idx_ff, idx_in;
   logic [PCntWidth-1:0] pfill_ff, pfill_in;
   logic [StatusWidth-1:0] status_ff, status_in;
   logic [ID_WIDTH-1:0]  moved_ff, moved_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   // Parked memory
   logic [ID_WIDTH-1:0]  park_mem [PARK_DEPTH];
   logic [ID_WIDTH-1:0]  park_rd_ff;
   logic                 park_we;
   logic [PIdxWidth-1:0] park_wa;
   logic [ID_WIDTH-1:0]  park_wd;
   logic [PIdxWidth-1:0] park_ra;

   // Helpers
   logic [31:0]          req_id_ext;
   logic [ID_WIDTH-1:0]  req_id;
   logic [31:0]          moved_ext;
   logic [31:0]          wait_count_ext;
   logic [31:0]          park_count_ext;
   logic [PCntWidth-1:0] idx_cnt;
   logic [PCntWidth-1:0] idx_plus1;
   logic [PCntWidth-1:0] pfill_dec;
   logic                 id_hit;
   logic                 at_newest;
   logic                 accept;
   logic                 rsp_free;
   op_type               req_op;

   qsk_fifo #(
      .WAIT_DEPTH (WAIT_DEPTH),
      .ID_WIDTH   (ID_WIDTH),
      .CNT_WIDTH  (WCntWidth)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .ctl     (fifo_ctl),
      .wr_data (id_in),
      .rd_data (fifo_rd_data),
      .stat    (fifo_stat),
      .count   (wait_count)
   );

   // Keep the low ID_WIDTH bits of the incoming ID
   assign req_id_ext = 32'(req_payload.item_id);
   assign req_id     = req_id_ext[ID_WIDTH-1:0];
   assign req_op     = op_type'(req_payload.operation);

   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign idx_cnt   = PCntWidth'(idx_ff);
   assign idx_plus1 = idx_cnt + PCntWidth'(1);
   assign pfill_dec = pfill_ff - PCntWidth'(1);
   assign at_newest = (idx_cnt == pfill_dec);

   // Shared comparator: stored entry against the key
   assign id_hit = (park_rd_ff == id_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_op == OP_PARK && !fifo_stat.empty
                   && pfill_ff < PCntWidth'(PARK_DEPTH)) begin
                  state_in = S_PARK_WR;
               end else if (req_op == OP_REMOVE && pfill_ff != '0) begin
                  state_in = S_SRCH_RD;
               end else begin
                  state_in = S_REPLY;
               end
            end
         end
         S_PARK_WR:  state_in = S_REPLY;
         S_SRCH_RD:  state_in = S_SRCH_CMP;
         S_SRCH_CMP: begin
            if (id_hit) begin
               state_in = at_newest ? S_REPLY : S_SHIFT_RD;
            end else if (idx_ff == '0) begin
               state_in = S_REPLY;
            end else begin
               state_in = S_SRCH_RD;
            end
         end
         S_SHIFT_RD: state_in = S_SHIFT_WR;
         S_SHIFT_WR: state_in = (idx_plus1 == pfill_dec) ? S_REPLY : S_SHIFT_RD;
         S_REPLY:    state_in = rsp_free ? S_IDLE : S_REPLY;
         default:    state_in = S_IDLE;
      endcase
   end

   // Datapath control
   always_comb begin
      id_in        = id_ff;
      idx_in       = idx_ff;
      pfill_in     = pfill_ff;
      status_in    = status_ff;
      moved_in     = moved_ff;
      fifo_ctl     = '0;
      park_we      = 1'b0;
      park_wa      = idx_ff;
      park_wd      = park_rd_ff;
      park_ra      = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               id_in     = req_id;
               status_in = ST_OK;
               moved_in  = '0;
               idx_in    = PIdxWidth'(pfill_dec);
               priority case (1'b1)
                  req_op == OP_ENQUEUE: begin
                     if (fifo_stat.full) begin
                        status_in = ST_QFULL;
                     end else begin
                        fifo_ctl.push = 1'b1;
                        moved_in      = req_id;
                     end
                  end
                  req_op == OP_PARK: begin
                     if (fifo_stat.empty) begin
                        status_in = ST_QEMPTY;
                     end else if (pfill_ff >= PCntWidth'(PARK_DEPTH)) begin
                        status_in = ST_PFULL;
                     end else begin
                        fifo_ctl.pop = 1'b1;
                     end
                  end
                  req_op == OP_REMOVE: begin
                     if (pfill_ff == '0) begin
                        status_in = ST_PEMPTY;
                     end
                  end
                  default: begin
                     status_in = ST_OK;
                  end
               endcase
            end
         end
         S_PARK_WR: begin
            // Push the popped ID onto the parked list
            park_we  = 1'b1;
            park_wa  = PIdxWidth'(pfill_ff);
            park_wd  = fifo_rd_data;
            pfill_in = pfill_ff + PCntWidth'(1);
            moved_in = fifo_rd_data;
         end
         S_SRCH_RD: begin
            park_ra = idx_ff;
         end
         S_SRCH_CMP: begin
            if (id_hit) begin
               if (at_newest) begin
                  pfill_in = pfill_dec;
                  moved_in = id_ff;
               end
            end else if (idx_ff == '0) begin
               status_in = ST_NOTFOUND;
            end else begin
               idx_in = idx_ff - PIdxWidth'(1);
            end
         end
         S_SHIFT_RD: begin
            park_ra = PIdxWidth'(idx_plus1);
         end
         S_SHIFT_WR: begin
            // Drop the gap by one entry
            park_we = 1'b1;
            park_wa = idx_ff;
            park_wd = park_rd_ff;
            idx_in  = PIdxWidth'(idx_plus1);
            if (idx_plus1 == pfill_dec) begin
               pfill_in = pfill_dec;
               moved_in = id_ff;
            end
         end
         S_REPLY: begin
            if (rsp_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.status        = status_ff;
               rsp_in.moved_id      = moved_ext[ItemIdWidth-1:0];
               rsp_in.waiting_count = wait_count_ext[CountWidth-1:0];
               rsp_in.parked_count  = park_count_ext[CountWidth-1:0];
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_ready;
         end
      endcase
   end

   assign moved_ext      = 32'(moved_ff);
   assign wait_count_ext = 32'(wait_count);
   assign park_count_ext = 32'(pfill_ff);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pfill_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pfill_ff     <= pfill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      id_ff     <= id_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      moved_ff  <= moved_in;
      rsp_ff    <= rsp_in;
   end

   // Parked memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (park_we) begin
         park_mem[park_wa] <= park_wd;
      end
      park_rd_ff <= park_mem[park_ra];
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
